>>> rtl/mpps_pkg.sv
// Shared types and constants for the multichannel plot point scaler.
package mpps_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_W       = 2;
    localparam int SAMPLE_W     = 24;
    localparam int DIFF_W       = 25;
    localparam int MAG_W        = 26;
    localparam int SCALE_W      = 20;
    localparam int SPEED_W      = 4;
    localparam int ROW_OUT_W    = 8;
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SPEED_W-1:0] MAX_SPEED   = 4'd10;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd100;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd1;

    typedef enum logic [2:0] {
        REG_NUM_CH1 = 3'd0,
        REG_DEN_CH1 = 3'd1,
        REG_NUM_CH2 = 3'd2,
        REG_DEN_CH2 = 3'd3,
        REG_NUM_CH3 = 3'd4,
        REG_DEN_CH3 = 3'd5,
        REG_SPEED   = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SAT,
        S_DIV,
        S_FIN,
        S_DELTA,
        S_ADV,
        S_EMIT_INT,
        S_EMIT_LAST
    } t_state;

endpackage

>>> rtl/multichannel_plot_point_scaler.sv
// Multichannel plot point scaler: recenter, bit-serial scale, clamp, row interpolation.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, i_chan, i_sample,       | in
//          | i_center_value, i_recenter                     |
//  out     | o_out_valid/i_out_ready, o_out_chan, o_row,    | out
//          | o_is_last                                      |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//          | pready (APB-style, 4-byte register spacing)    |
//
// Steps: an item is loaded, then multiplied bit-serially (one multiplier bit per
//   cycle), saturation-checked and divided by a restoring divide (skipped when the
//   quotient saturates), then clamped and compared with the last row; for speed
//   s > 2, |delta|/s runs on the same divider, and each interpolated row and
//   the final row are emitted in turn.
// Reset: synchronous, active low; clears config to defaults and zeroes the
//   per-channel offsets and last rows.
// Stalls: a single output register holds each row; the sequencer waits on it
//   while i_out_ready is low. A new item is taken once the final row of the
//   previous item sits in the output register.
module multichannel_plot_point_scaler
    import mpps_pkg::*;
#(
    parameter int PLOT_HEIGHT = 200
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [CHAN_W-1:0]          i_chan,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_center_value,
    input  logic                       i_recenter,
    // result items
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [CHAN_W-1:0]          o_out_chan,
    output logic [ROW_OUT_W-1:0]       o_row,
    output logic                       o_is_last,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_W-1:0]      paddr,
    input  logic [CFG_DATA_W-1:0]      pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // internal row width covers 0 .. PLOT_HEIGHT-1
    localparam int ROW_W  = $clog2(PLOT_HEIGHT);
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int DIVD_W = SCALE_W + ROW_W;
    localparam int CNT_W  = $clog2((SCALE_W > ROW_W ? SCALE_W : ROW_W) + 1);

    localparam logic [ROW_W-1:0]        ROW_ONE_V = ROW_W'(1);
    localparam logic [ROW_W-1:0]        ROW_MAX_V = ROW_W'(PLOT_HEIGHT - 2);
    localparam logic signed [ROW_W+1:0] HALF_S    = (ROW_W+2)'(PLOT_HEIGHT / 2);
    localparam logic signed [ROW_W+1:0] ONE_S     = (ROW_W+2)'(1);
    localparam logic signed [ROW_W+1:0] MAX_S     = (ROW_W+2)'(PLOT_HEIGHT - 2);

    // ---------------- configuration registers ----------------
    logic [SCALE_W-1:0] r_num [3];
    logic [SCALE_W-1:0] r_den [3];
    logic [SPEED_W-1:0] r_speed;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (paddr[4:2])
            REG_NUM_CH1: prdata = CFG_DATA_W'(r_num[0]);
            REG_DEN_CH1: prdata = CFG_DATA_W'(r_den[0]);
            REG_NUM_CH2: prdata = CFG_DATA_W'(r_num[1]);
            REG_DEN_CH2: prdata = CFG_DATA_W'(r_den[1]);
            REG_NUM_CH3: prdata = CFG_DATA_W'(r_num[2]);
            REG_DEN_CH3: prdata = CFG_DATA_W'(r_den[2]);
            REG_SPEED:   prdata = CFG_DATA_W'(r_speed);
            default:     prdata = '0;
        endcase
    end

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic signed [DIFF_W-1:0] r_offset [NUM_CHANNELS];
    logic [ROW_W-1:0]         r_last   [NUM_CHANNELS];

    logic                     r_out_valid, n_out_valid;
    logic [CHAN_W-1:0]        r_out_chan, n_out_chan;
    logic [ROW_W-1:0]         r_out_row, n_out_row;
    logic                     r_out_last, n_out_last;

    logic [CHAN_W-1:0]        r_ch;
    logic signed [DIFF_W-1:0] r_diff;
    logic                     r_neg, n_neg;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic [SCALE_W-1:0]       r_mplier, n_mplier;
    logic [SCALE_W-1:0]       r_dvsr, n_dvsr;
    logic [PROD_W-1:0]        r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic [DIVD_W-1:0]        r_rem, n_rem;
    logic [DIVD_W-1:0]        r_dsh, n_dsh;
    logic [ROW_W-1:0]         r_q, n_q;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_phase2, n_phase2;
    logic [ROW_W-1:0]         r_row_new, n_row_new;
    logic [ROW_W-1:0]         r_prev, n_prev;
    logic [ROW_W-1:0]         r_dmag, n_dmag;
    logic                     r_dneg, n_dneg;
    logic [SPEED_W-1:0]       r_spd, n_spd;
    logic [SPEED_W-1:0]       r_n, n_n;
    logic [SPEED_W-1:0]       r_k, n_k;
    logic [ROW_W-1:0]         r_iq, n_iq;
    logic [SPEED_W-1:0]       r_ir, n_ir;

    // ---------------- shared combinational terms ----------------
    logic                     w_accept;
    logic                     w_slot_free;
    logic signed [DIFF_W-1:0] w_diff_in;
    logic [1:0]               w_sidx;
    logic signed [MAG_W-1:0]  w_v;
    logic                     w_sat;
    logic                     w_ge;
    logic signed [ROW_W+1:0]  w_qs;
    logic signed [ROW_W+1:0]  w_sv;
    logic [SPEED_W-1:0]       w_spd;
    logic [SPEED_W-1:0]       w_nint;
    logic [SPEED_W:0]         w_rsum;
    logic [ROW_W+7:0]         w_row_ext;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_diff_in   = {i_sample[SAMPLE_W-1], i_sample}
                       - {i_center_value[SAMPLE_W-1], i_center_value};
    assign w_sidx      = 2'(r_ch - 2'd1);
    assign w_v         = {r_diff[DIFF_W-1], r_diff}
                       - {r_offset[r_ch][DIFF_W-1], r_offset[r_ch]};
    // quotient would reach 2^ROW_W: always clamps
    assign w_sat       = r_acc >= PROD_W'({r_dvsr, {ROW_W{1'b0}}});
    assign w_ge        = r_rem >= r_dsh;
    assign w_qs        = r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
    assign w_sv        = w_qs + HALF_S;
    assign w_spd       = (r_speed > MAX_SPEED) ? MAX_SPEED : r_speed;
    assign w_nint      = (w_spd > 4'd2) ? 4'(w_spd - 4'd2) : '0;
    assign w_rsum      = {1'b0, r_ir} + {1'b0, r_rem[SPEED_W-1:0]};

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_LOAD;
            S_LOAD:      n_state = S_MUL;
            S_MUL:       if (r_cnt == CNT_W'(1)) n_state = S_SAT;
            S_SAT:       n_state = w_sat ? S_FIN : S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(1)) n_state = r_phase2 ? S_ADV : S_FIN;
            end
            S_FIN:       n_state = S_DELTA;
            S_DELTA:     n_state = (w_nint == '0) ? S_EMIT_LAST : S_DIV;
            S_ADV:       n_state = S_EMIT_INT;
            S_EMIT_INT: begin
                if (w_slot_free) n_state = (r_k == r_n) ? S_EMIT_LAST : S_ADV;
            end
            S_EMIT_LAST: if (w_slot_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_mplier    = r_mplier;
        n_dvsr      = r_dvsr;
        n_acc       = r_acc;
        n_sat       = r_sat;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_phase2    = r_phase2;
        n_row_new   = r_row_new;
        n_prev      = r_prev;
        n_dmag      = r_dmag;
        n_dneg      = r_dneg;
        n_spd       = r_spd;
        n_n         = r_n;
        n_k         = r_k;
        n_iq        = r_iq;
        n_ir        = r_ir;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_chan  = r_out_chan;
        n_out_row   = r_out_row;
        n_out_last  = r_out_last;

        case (r_state)
            S_LOAD: begin
                n_neg    = w_v[MAG_W-1];
                n_mag    = w_v[MAG_W-1] ? MAG_W'(-w_v) : MAG_W'(w_v);
                n_acc    = '0;
                n_cnt    = CNT_W'(SCALE_W);
                n_phase2 = 1'b0;
                n_sat    = 1'b0;
                if (r_ch == '0) begin
                    // tare trace: unscaled
                    n_mplier = SCALE_W'(1);
                    n_dvsr   = SCALE_W'(1);
                end else begin
                    n_mplier = r_num[w_sidx];
                    n_dvsr   = (r_den[w_sidx] == '0) ? SCALE_W'(1) : r_den[w_sidx];
                end
            end
            S_MUL: begin
                // MSB-first shift and add
                n_acc    = {r_acc[PROD_W-2:0], 1'b0}
                         + (r_mplier[SCALE_W-1] ? PROD_W'(r_mag) : '0);
                n_mplier = {r_mplier[SCALE_W-2:0], 1'b0};
                n_cnt    = CNT_W'(r_cnt - CNT_W'(1));
            end
            S_SAT: begin
                n_sat = w_sat;
                n_rem = r_acc[DIVD_W-1:0];
                n_dsh = DIVD_W'(r_dvsr) << (ROW_W - 1);
                n_q   = '0;
                n_cnt = CNT_W'(ROW_W);
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                n_rem = w_ge ? DIVD_W'(r_rem - r_dsh) : r_rem;
                n_q   = {r_q[ROW_W-2:0], w_ge};
                n_dsh = r_dsh >> 1;
                n_cnt = CNT_W'(r_cnt - CNT_W'(1));
            end
            S_FIN: begin
                if (r_sat) begin
                    n_row_new = r_neg ? ROW_ONE_V : ROW_MAX_V;
                end else if (w_sv < ONE_S) begin
                    n_row_new = ROW_ONE_V;
                end else if (w_sv > MAX_S) begin
                    n_row_new = ROW_MAX_V;
                end else begin
                    n_row_new = w_sv[ROW_W-1:0];
                end
            end
            S_DELTA: begin
                n_prev = r_last[r_ch];
                if (r_row_new >= r_last[r_ch]) begin
                    n_dmag = ROW_W'(r_row_new - r_last[r_ch]);
                    n_dneg = 1'b0;
                end else begin
                    n_dmag = ROW_W'(r_last[r_ch] - r_row_new);
                    n_dneg = 1'b1;
                end
                n_spd    = w_spd;
                n_n      = w_nint;
                n_k      = '0;
                n_iq     = '0;
                n_ir     = '0;
                n_phase2 = 1'b1;
                // |delta| / speed on the same divider
                n_rem    = DIVD_W'(n_dmag);
                n_dsh    = DIVD_W'(w_spd) << (ROW_W - 1);
                n_q      = '0;
                n_cnt    = CNT_W'(ROW_W);
            end
            S_ADV: begin
                // running floor(|delta|*k/speed) from quotient and remainder
                n_k = SPEED_W'(r_k + SPEED_W'(1));
                if (w_rsum >= {1'b0, r_spd}) begin
                    n_ir = SPEED_W'(w_rsum - {1'b0, r_spd});
                    n_iq = ROW_W'(r_iq + r_q + ROW_W'(1));
                end else begin
                    n_ir = w_rsum[SPEED_W-1:0];
                    n_iq = ROW_W'(r_iq + r_q);
                end
            end
            S_EMIT_INT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_chan  = r_ch;
                    n_out_row   = r_dneg ? ROW_W'(r_prev - r_iq) : ROW_W'(r_prev + r_iq);
                    n_out_last  = 1'b0;
                end
            end
            S_EMIT_LAST: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_chan  = r_ch;
                    n_out_row   = r_row_new;
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_speed     <= SPEED_RESET;
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= SCALE_RESET;
                r_den[i] <= SCALE_RESET;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_offset[i] <= '0;
                r_last[i]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_NUM_CH1: r_num[0] <= pwdata[SCALE_W-1:0];
                    REG_DEN_CH1: r_den[0] <= pwdata[SCALE_W-1:0];
                    REG_NUM_CH2: r_num[1] <= pwdata[SCALE_W-1:0];
                    REG_DEN_CH2: r_den[1] <= pwdata[SCALE_W-1:0];
                    REG_NUM_CH3: r_num[2] <= pwdata[SCALE_W-1:0];
                    REG_DEN_CH3: r_den[2] <= pwdata[SCALE_W-1:0];
                    REG_SPEED:   r_speed  <= pwdata[SPEED_W-1:0];
                    default: ;
                endcase
            end
            // recenter: offset takes sample - center; channel 1 also moves channel 0
            if (w_accept && i_recenter && (i_chan != '0)) begin
                r_offset[i_chan] <= w_diff_in;
                if (i_chan == CHAN_W'(1)) r_offset[0] <= w_diff_in;
            end
            if ((r_state == S_EMIT_LAST) && w_slot_free) r_last[r_ch] <= r_row_new;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= i_chan;
            r_diff <= w_diff_in;
        end
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_mplier   <= n_mplier;
        r_dvsr     <= n_dvsr;
        r_acc      <= n_acc;
        r_sat      <= n_sat;
        r_rem      <= n_rem;
        r_dsh      <= n_dsh;
        r_q        <= n_q;
        r_cnt      <= n_cnt;
        r_phase2   <= n_phase2;
        r_row_new  <= n_row_new;
        r_prev     <= n_prev;
        r_dmag     <= n_dmag;
        r_dneg     <= n_dneg;
        r_spd      <= n_spd;
        r_n        <= n_n;
        r_k        <= n_k;
        r_iq       <= n_iq;
        r_ir       <= n_ir;
        r_out_chan <= n_out_chan;
        r_out_row  <= n_out_row;
        r_out_last <= n_out_last;
    end

    assign w_row_ext   = {8'd0, r_out_row};
    assign o_out_valid = r_out_valid;
    assign o_out_chan  = r_out_chan;
    assign o_row       = w_row_ext[ROW_OUT_W-1:0];
    assign o_is_last   = r_out_last;

    // ---------------- assertions ----------------
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_row <= ROW_MAX_V) && (!o_is_last || r_out_row >= ROW_ONE_V))
        else $error("plotted row outside graph");

    a_interp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_INT) |-> (r_iq <= r_dmag))
        else $error("interpolation step overshoots delta");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_INT) |-> (r_ir < r_spd))
        else $error("interpolation remainder not reduced");

    a_final_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT_LAST) && w_slot_free)
            |=> (o_out_valid && o_is_last && (r_state == S_IDLE)))
        else $error("final row not presented");

endmodule
